[rtl/rle8_pkg.sv]
// Shared types and constants for the BMP RLE8 stream decoder.
// Used by every module under rtl; depends on nothing.
`default_nettype none

package rle8_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_LINE_STRIDE  = 2'd0;
    localparam logic [1:0] CFG_LINE_COUNT   = 2'd1;
    localparam logic [1:0] CFG_STREAM_LIMIT = 2'd2;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 28;
    localparam int STRIDE_BITS    = 14;
    localparam int COUNT_BITS     = 14;
    localparam int LIMIT_BITS     = 28;

    localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 14'd4;
    localparam logic [COUNT_BITS-1:0]  COUNT_RESET  = 14'd1;
    localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = 28'd1;

    // Consumed byte counter saturates here
    localparam logic [LIMIT_BITS-1:0] CONSUMED_MAX = 28'hFFF_FFFF;

    // Parser phases
    localparam logic [2:0] PH_CMD      = 3'd0;
    localparam logic [2:0] PH_COLOR    = 3'd1;
    localparam logic [2:0] PH_ESC      = 3'd2;
    localparam logic [2:0] PH_DX       = 3'd3;
    localparam logic [2:0] PH_DY       = 3'd4;
    localparam logic [2:0] PH_LIT_EVEN = 3'd5;
    localparam logic [2:0] PH_LIT_ODD  = 3'd6;
    localparam logic [2:0] PH_PAD      = 3'd7;

    // Stream codes
    localparam logic [7:0] RLE_ESCAPE = 8'd0;
    localparam logic [7:0] ESC_EOL    = 8'd0;
    localparam logic [7:0] ESC_EOB    = 8'd1;
    localparam logic [7:0] ESC_DELTA  = 8'd2;

    typedef struct packed {
        logic [7:0] run_length;
        logic [7:0] pixel_value;
        logic       image_done;
    } cmd_t;

endpackage

`default_nettype wire

[rtl/rle8_cfg.sv]
// Configuration registers and the derived buffer end address.
// Depends on rle8_pkg.
`default_nettype none

module rle8_cfg
    import rle8_pkg::*;
#(
    parameter int ADDRESS_BITS = 28
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    output logic [STRIDE_BITS-1:0]         line_stride,
    output logic [LIMIT_BITS-1:0]          stream_limit,
    output logic [ADDRESS_BITS-1:0]        buffer_end
);

    localparam int PW = (ADDRESS_BITS > 28) ? ADDRESS_BITS : 28;
    localparam logic [PW-1:0] CAP = PW'((64'd1 << ADDRESS_BITS) - 64'd1);

    logic [STRIDE_BITS-1:0]  stride_reg, stride_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [LIMIT_BITS-1:0]   limit_reg, limit_next;
    logic [ADDRESS_BITS-1:0] end_reg, end_next;
    logic [27:0]             size;
    logic [PW-1:0]           size_ext;
    logic                    wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    always_comb
    begin
        stride_next = stride_reg;
        count_next  = count_reg;
        limit_next  = limit_reg;
        if (wr)
        begin
            case (cfg_index)
                CFG_LINE_STRIDE:  stride_next = cfg_data[STRIDE_BITS-1:0];
                CFG_LINE_COUNT:   count_next  = cfg_data[COUNT_BITS-1:0];
                CFG_STREAM_LIMIT: limit_next  = cfg_data[LIMIT_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Buffer end follows the register values of the next cycle
    assign size     = stride_next * count_next;
    assign size_ext = PW'(size);
    assign end_next = (size_ext < CAP) ? size_ext[ADDRESS_BITS-1:0] : CAP[ADDRESS_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= STRIDE_RESET;
            count_reg  <= COUNT_RESET;
            limit_reg  <= LIMIT_RESET;
            end_reg    <= ADDRESS_BITS'(STRIDE_RESET * COUNT_RESET);
        end
        else
        begin
            stride_reg <= stride_next;
            count_reg  <= count_next;
            limit_reg  <= limit_next;
            end_reg    <= end_next;
        end
    end

    assign line_stride  = stride_reg;
    assign stream_limit = limit_reg;
    assign buffer_end   = end_reg;

endmodule

`default_nettype wire

[rtl/rle8_core.sv]
// RLE8 parser: decode state and the per-byte command logic.
// Depends on rle8_pkg; fed by rle8_cfg, drains into rle8_outreg.
`default_nettype none

module rle8_core
    import rle8_pkg::*;
#(
    parameter int ADDRESS_BITS = 28
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    accept,
    input  wire logic [7:0]              data_byte,
    input  wire logic                    first_of_image,
    input  wire logic [STRIDE_BITS-1:0]  line_stride,
    input  wire logic [LIMIT_BITS-1:0]   stream_limit,
    input  wire logic [ADDRESS_BITS-1:0] buffer_end,
    output logic                         res_have,
    output logic [ADDRESS_BITS-1:0]      res_addr,
    output cmd_t                         res_cmd
);

    localparam int SW = ((ADDRESS_BITS > 22) ? ADDRESS_BITS : 22) + 2;

    logic [2:0]              phase_reg, phase_next, eff_phase;
    logic [7:0]              cnt_reg, cnt_next, eff_cnt;
    logic [7:0]              dx_reg, dx_next, eff_dx;
    logic [ADDRESS_BITS-1:0] wp_reg, wp_next, eff_wp;
    logic [ADDRESS_BITS-1:0] ls_reg, ls_next, eff_ls;
    logic [LIMIT_BITS-1:0]   bc_reg, bc_next, eff_bc;
    logic                    fin_reg, fin_next, eff_fin;

    logic [ADDRESS_BITS-1:0] room;
    logic                    has_room;
    logic [7:0]              run_len;
    logic [21:0]             dy_prod;
    logic [SW-1:0]           dy_sum, eol_sum;
    logic [ADDRESS_BITS-1:0] dy_wp, eol_ls;
    logic [7:0]              cnt_dec;
    logic                    done_now;

    // First byte of an image restarts from the cleared state
    assign eff_phase = first_of_image ? PH_CMD : phase_reg;
    assign eff_cnt   = first_of_image ? 8'd0 : cnt_reg;
    assign eff_dx    = first_of_image ? 8'd0 : dx_reg;
    assign eff_wp    = first_of_image ? '0 : wp_reg;
    assign eff_ls    = first_of_image ? '0 : ls_reg;
    assign eff_bc    = first_of_image ? '0 : bc_reg;
    assign eff_fin   = first_of_image ? 1'b0 : fin_reg;

    // Run clipped to the room left before the buffer end
    assign has_room = buffer_end > eff_wp;
    assign room     = buffer_end - eff_wp;
    assign run_len  = !has_room ? 8'd0
                    : (room < ADDRESS_BITS'(eff_cnt)) ? room[7:0] : eff_cnt;

    assign dy_prod = data_byte * line_stride;
    assign dy_sum  = SW'(eff_wp) + SW'(eff_dx) + SW'(dy_prod);
    assign dy_wp   = (dy_sum < SW'(buffer_end)) ? dy_sum[ADDRESS_BITS-1:0] : buffer_end;
    assign eol_sum = SW'(eff_ls) + SW'(line_stride);
    assign eol_ls  = (eol_sum < SW'(buffer_end)) ? eol_sum[ADDRESS_BITS-1:0] : buffer_end;
    assign cnt_dec = (eff_cnt != 8'd0) ? eff_cnt - 8'd1 : 8'd0;

    always_comb
    begin
        phase_next = eff_phase;
        cnt_next   = eff_cnt;
        dx_next    = eff_dx;
        wp_next    = eff_wp;
        ls_next    = eff_ls;
        bc_next    = eff_bc;
        fin_next   = eff_fin;
        res_have   = 1'b0;
        res_addr   = eff_wp;
        res_cmd    = '0;
        done_now   = 1'b0;

        if (!eff_fin)
        begin
            if (eff_phase == PH_CMD && (eff_wp >= buffer_end || eff_bc >= stream_limit))
            begin
                // Leave the byte unconsumed and report the end
                fin_next           = 1'b1;
                res_have           = 1'b1;
                res_cmd.image_done = 1'b1;
            end
            else
            begin
                bc_next = (eff_bc != CONSUMED_MAX) ? eff_bc + 1'b1 : eff_bc;
                case (eff_phase)
                    PH_CMD:
                    begin
                        if (data_byte == RLE_ESCAPE)
                        begin
                            phase_next = PH_ESC;
                        end
                        else
                        begin
                            cnt_next   = data_byte;
                            phase_next = PH_COLOR;
                        end
                    end
                    PH_COLOR:
                    begin
                        if (run_len != 8'd0)
                        begin
                            res_have            = 1'b1;
                            res_cmd.run_length  = run_len;
                            res_cmd.pixel_value = data_byte;
                        end
                        // Saturate at the buffer end when no room is left
                        wp_next    = has_room ? eff_wp + ADDRESS_BITS'(run_len) : buffer_end;
                        phase_next = PH_CMD;
                    end
                    PH_ESC:
                    begin
                        case (data_byte)
                            ESC_EOL:
                            begin
                                ls_next    = eol_ls;
                                wp_next    = eol_ls;
                                phase_next = PH_CMD;
                            end
                            ESC_EOB:
                            begin
                                done_now   = 1'b1;
                                phase_next = PH_CMD;
                            end
                            ESC_DELTA:
                            begin
                                phase_next = PH_DX;
                            end
                            default:
                            begin
                                cnt_next   = data_byte;
                                phase_next = data_byte[0] ? PH_LIT_ODD : PH_LIT_EVEN;
                            end
                        endcase
                    end
                    PH_DX:
                    begin
                        dx_next    = data_byte;
                        phase_next = PH_DY;
                    end
                    PH_DY:
                    begin
                        wp_next    = dy_wp;
                        phase_next = PH_CMD;
                    end
                    PH_LIT_EVEN, PH_LIT_ODD:
                    begin
                        // Drop literals that fall past the buffer end
                        if (has_room)
                        begin
                            res_have            = 1'b1;
                            res_cmd.run_length  = 8'd1;
                            res_cmd.pixel_value = data_byte;
                            wp_next             = eff_wp + 1'b1;
                        end
                        cnt_next = cnt_dec;
                        if (cnt_dec == 8'd0)
                        begin
                            phase_next = (eff_phase == PH_LIT_ODD) ? PH_PAD : PH_CMD;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_CMD;
                    end
                endcase

                if (bc_next >= stream_limit)
                begin
                    done_now = 1'b1;
                end
                if (phase_next == PH_CMD && wp_next >= buffer_end)
                begin
                    done_now = 1'b1;
                end

                if (done_now)
                begin
                    fin_next = 1'b1;
                    if (res_have)
                    begin
                        res_cmd.image_done = 1'b1;
                    end
                    else
                    begin
                        res_have           = 1'b1;
                        res_addr           = wp_next;
                        res_cmd            = '0;
                        res_cmd.image_done = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CMD;
            cnt_reg   <= '0;
            dx_reg    <= '0;
            wp_reg    <= '0;
            ls_reg    <= '0;
            bc_reg    <= '0;
            fin_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            dx_reg    <= dx_next;
            wp_reg    <= wp_next;
            ls_reg    <= ls_next;
            bc_reg    <= bc_next;
            fin_reg   <= fin_next;
        end
    end

    // A finished image stays silent until the next first byte
    a_silent_when_finished: assert property (@(posedge clk) disable iff (!rst_n)
        accept && fin_reg && !first_of_image |-> !res_have)
        else $error("result produced after image finished");

    // Only the done marker carries a zero length
    a_nonzero_run: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_have && !res_cmd.image_done |-> res_cmd.run_length != 8'd0)
        else $error("empty run command");

    // The end report always leaves the parser finished
    a_done_sets_finished: assert property (@(posedge clk) disable iff (!rst_n)
        accept && res_have && res_cmd.image_done |=> fin_reg)
        else $error("image_done without finished state");

    // Bytes are never consumed once finished
    a_count_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        accept && fin_reg && !first_of_image |=> $stable(bc_reg))
        else $error("byte consumed after finish");

endmodule

`default_nettype wire

[rtl/rle8_outreg.sv]
// Output register for write commands; parts the stream input from the
// command receiver. Depends on rle8_pkg.
`default_nettype none

module rle8_outreg
    import rle8_pkg::*;
#(
    parameter int ADDRESS_BITS = 28
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  wire logic [ADDRESS_BITS-1:0] load_addr,
    input  wire cmd_t                    load_cmd,
    output logic                         space,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [ADDRESS_BITS-1:0]      out_addr,
    output cmd_t                         out_cmd
);

    logic                    valid_reg, valid_next;
    logic [ADDRESS_BITS-1:0] addr_reg;
    cmd_t                    cmd_reg;

    // A slot is free when empty or drained in this cycle
    assign space = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_reg <= load_addr;
            cmd_reg  <= load_cmd;
        end
    end

    assign out_valid = valid_reg;
    assign out_addr  = addr_reg;
    assign out_cmd   = cmd_reg;

endmodule

`default_nettype wire

[rtl/bmp_rle8_decoder.sv]
// BMP RLE8 decoder top level: configuration registers, parser and output
// register. Depends on rle8_pkg, rle8_cfg, rle8_core and rle8_outreg.
//
// Usage:
//   s_* carries one compressed byte per transaction; s_tuser = 1 marks the
//   first byte of an image and restarts the decoding state there.
//   m_* carries write commands: address, run length and palette index.
//   m_tlast marks the command that ends the image (a run, or a done marker
//   with run length 0 at the current write address).
//   cfg_* writes line_stride (0), line_count (1) and stream_limit (2) while
//   the decoder is idle; cfg_ready is always high, other indexes are ignored.
// Timing:
//   One byte per cycle while s_tready is high. A command appears on m_* in
//   the cycle after its byte; bytes that only advance the parser give nothing.
//   Throughput is set by the single output register: s_tready is low only
//   while that register holds a command and m_tready is low.
// Reset:
//   rst_n clears the parser to expect a count or escape at address zero and
//   loads the register defaults (stride 4, one line, limit of one byte).
`default_nettype none

module bmp_rle8_decoder
    import rle8_pkg::*;
#(
    parameter int ADDRESS_BITS = 28
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [7:0]                s_tdata,   // [7:0] data_byte
    input  wire logic                      s_tuser,   // [0] first_of_image
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // dest_address, run_length, pixel_value from the lowest bit, zero fill
    output logic [((ADDRESS_BITS+16+7)/8)*8-1:0] m_tdata,
    output logic                           m_tlast,   // image_done
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int OW = ((ADDRESS_BITS + 16 + 7) / 8) * 8;

    logic [STRIDE_BITS-1:0]  line_stride;
    logic [LIMIT_BITS-1:0]   stream_limit;
    logic [ADDRESS_BITS-1:0] buffer_end;
    logic                    accept;
    logic                    res_have;
    logic [ADDRESS_BITS-1:0] res_addr;
    cmd_t                    res_cmd;
    logic [ADDRESS_BITS-1:0] out_addr;
    cmd_t                    out_cmd;
    logic                    space;

    rle8_cfg #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .line_stride  (line_stride),
        .stream_limit (stream_limit),
        .buffer_end   (buffer_end)
    );

    assign s_tready = space;
    assign accept   = s_tvalid && s_tready;

    rle8_core #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .data_byte      (s_tdata),
        .first_of_image (s_tuser),
        .line_stride    (line_stride),
        .stream_limit   (stream_limit),
        .buffer_end     (buffer_end),
        .res_have       (res_have),
        .res_addr       (res_addr),
        .res_cmd        (res_cmd)
    );

    rle8_outreg #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_outreg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept && res_have),
        .load_addr (res_addr),
        .load_cmd  (res_cmd),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_addr  (out_addr),
        .out_cmd   (out_cmd)
    );

    assign m_tdata = OW'({out_cmd.pixel_value, out_cmd.run_length, out_addr});
    assign m_tlast = out_cmd.image_done;

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for bmp_rle8_decoder: drives RLE8 byte streams,
// predicts the write commands and compares them. Depends on rle8_pkg and
// the decoder RTL.
`default_nettype none

module testbench;
    import rle8_pkg::*;

    localparam int ADDR_BITS   = 28;
    localparam int CMD_BITS    = ((ADDR_BITS + 16 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 6;
    localparam int PHASE_ITEMS = 160;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [ADDR_BITS-1:0] addr;
        logic [7:0]           len;
        logic [7:0]           pix;
        logic                 done;
    } write_cmd_t;

    class rle8_scoreboard;
        logic [STRIDE_BITS-1:0] stride;
        logic [COUNT_BITS-1:0]  lines;
        logic [LIMIT_BITS-1:0]  limit;
        logic [2:0]             phase;
        logic [7:0]             count;
        logic [7:0]             dx;
        longint unsigned        wp;
        longint unsigned        line_base;
        logic [LIMIT_BITS-1:0]  consumed;
        bit                     finished;
        write_cmd_t             cmd_q[$];
        int                     errors;

        function new();
            stride = STRIDE_RESET;
            lines  = COUNT_RESET;
            limit  = LIMIT_RESET;
            errors = 0;
            restart();
        endfunction

        function void restart();
            phase     = PH_CMD;
            count     = '0;
            dx        = '0;
            wp        = 0;
            line_base = 0;
            consumed  = '0;
            finished  = 1'b0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                CFG_LINE_STRIDE:  stride = val[STRIDE_BITS-1:0];
                CFG_LINE_COUNT:   lines  = val[COUNT_BITS-1:0];
                CFG_STREAM_LIMIT: limit  = val[LIMIT_BITS-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned buf_limit();
            longint unsigned cap;
            longint unsigned size;
            cap  = (longint'(1) << ADDR_BITS) - 1;
            size = longint'(stride) * longint'(lines);
            return (size < cap) ? size : cap;
        endfunction

        function longint unsigned clamp(longint unsigned v);
            longint unsigned lim;
            lim = buf_limit();
            return (v < lim) ? v : lim;
        endfunction

        function void push(longint unsigned addr, logic [7:0] len, logic [7:0] pix,
                           logic done);
            write_cmd_t c;
            c.addr = addr[ADDR_BITS-1:0];
            c.len  = len;
            c.pix  = pix;
            c.done = done;
            cmd_q.push_back(c);
        endfunction

        function int pending();
            return cmd_q.size();
        endfunction

        // Returns 1 when the byte is acted on, 0 when the decoder ignores it.
        function bit note_byte(logic [7:0] b, logic first);
            longint unsigned lim;
            longint unsigned room;
            logic [7:0]      len;
            bit              have;
            bit              done_now;
            have     = 1'b0;
            done_now = 1'b0;
            if (first)
                restart();
            if (finished)
                return 1'b0;
            lim = buf_limit();
            // End check at a command start: the byte is not consumed
            if (phase == PH_CMD && (wp >= lim || consumed >= limit)) begin
                finished = 1'b1;
                push(wp, 8'd0, 8'd0, 1'b1);
                return 1'b1;
            end
            if (consumed != CONSUMED_MAX)
                consumed = consumed + 1'b1;
            case (phase)
                PH_CMD:
                begin
                    if (b == RLE_ESCAPE)
                        phase = PH_ESC;
                    else
                    begin
                        count = b;
                        phase = PH_COLOR;
                    end
                end
                PH_COLOR:
                begin
                    room = (lim > wp) ? lim - wp : 0;
                    len  = (longint'(count) < room) ? count : room[7:0];
                    if (len != 0)
                    begin
                        push(wp, len, b, 1'b0);
                        have = 1'b1;
                    end
                    wp    = clamp(wp + longint'(len));
                    phase = PH_CMD;
                end
                PH_ESC:
                begin
                    if (b == ESC_EOL)
                    begin
                        line_base = clamp(line_base + longint'(stride));
                        wp        = line_base;
                        phase     = PH_CMD;
                    end
                    else if (b == ESC_EOB)
                    begin
                        done_now = 1'b1;
                        phase    = PH_CMD;
                    end
                    else if (b == ESC_DELTA)
                        phase = PH_DX;
                    else
                    begin
                        count = b;
                        phase = b[0] ? PH_LIT_ODD : PH_LIT_EVEN;
                    end
                end
                PH_DX:
                begin
                    dx    = b;
                    phase = PH_DY;
                end
                PH_DY:
                begin
                    wp    = clamp(wp + longint'(dx) + longint'(b) * longint'(stride));
                    phase = PH_CMD;
                end
                PH_LIT_EVEN, PH_LIT_ODD:
                begin
                    if (wp < lim)
                    begin
                        push(wp, 8'd1, b, 1'b0);
                        have = 1'b1;
                        wp   = clamp(wp + 1);
                    end
                    if (count != 0)
                        count = count - 1'b1;
                    if (count == 0)
                        phase = (phase == PH_LIT_ODD) ? PH_PAD : PH_CMD;
                end
                default:
                    phase = PH_CMD;
            endcase
            if (consumed >= limit)
                done_now = 1'b1;
            if (phase == PH_CMD && wp >= buf_limit())
                done_now = 1'b1;
            if (done_now)
            begin
                finished = 1'b1;
                // A run from this byte carries the end flag itself
                if (have)
                    cmd_q[cmd_q.size()-1].done = 1'b1;
                else
                    push(wp, 8'd0, 8'd0, 1'b1);
            end
            return 1'b1;
        endfunction

        function void check_cmd(logic [CMD_BITS-1:0] data, logic last);
            write_cmd_t exp_cmd;
            logic [ADDR_BITS-1:0] addr;
            logic [7:0]           len;
            logic [7:0]           pix;
            addr = data[ADDR_BITS-1:0];
            len  = data[ADDR_BITS+7:ADDR_BITS];
            pix  = data[ADDR_BITS+15:ADDR_BITS+8];
            if (cmd_q.size() == 0)
            begin
                $error("unexpected command: dest_address %0h run_length %0d", addr, len);
                errors++;
                return;
            end
            exp_cmd = cmd_q.pop_front();
            if (addr !== exp_cmd.addr)
            begin
                $error("dest_address: expected %0h, got %0h", exp_cmd.addr, addr);
                errors++;
            end
            if (len !== exp_cmd.len)
            begin
                $error("run_length: expected %0d, got %0d", exp_cmd.len, len);
                errors++;
            end
            if (pix !== exp_cmd.pix)
            begin
                $error("pixel_value: expected %0h, got %0h", exp_cmd.pix, pix);
                errors++;
            end
            if (last !== exp_cmd.done)
            begin
                $error("image_done: expected %0b, got %0b", exp_cmd.done, last);
                errors++;
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [7:0]                s_tdata;
    logic                      s_tuser;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [CMD_BITS-1:0]       m_tdata;
    logic                      m_tlast;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    rle8_scoreboard sb;
    int  src_idle;
    int  snk_stall;
    int  items_sent;
    int  cycle_count;
    bit  first_pending;

    bmp_rle8_decoder #(.ADDRESS_BITS(ADDR_BITS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Command sink: check each transaction, then draw the next stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_cmd(m_tdata, m_tlast);
            m_tready <= ($urandom_range(99) >= snk_stall);
        end
    end

    task automatic send_byte(logic [7:0] b);
        logic first;
        first         = first_pending;
        first_pending = 1'b0;
        if ($urandom_range(99) < src_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < src_idle)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (sb.note_byte(b, first))
            items_sent++;
    endtask

    // Keep cfg_valid high across back-to-back writes; the caller lowers it.
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task automatic configure(logic [CFG_DATA_BITS-1:0] stride, logic [CFG_DATA_BITS-1:0] lines,
                             logic [CFG_DATA_BITS-1:0] limit);
        write_reg(CFG_LINE_STRIDE, stride);
        write_reg(CFG_LINE_COUNT, lines);
        write_reg(CFG_STREAM_LIMIT, limit);
        cfg_valid <= 1'b0;
    endtask

    // Hold the stream until every command is out, then let the parser settle.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic pick_config();
        logic [CFG_DATA_BITS-1:0] limit;
        limit = ($urandom_range(1) != 0) ? CONSUMED_MAX
                                         : CFG_DATA_BITS'($urandom_range(1, 150));
        case ($urandom_range(11))
            0: configure(28'd16383, 28'd16383, CONSUMED_MAX);
            1: configure(28'd1, 28'd1, CFG_DATA_BITS'($urandom_range(1, 4)));
            2: configure(28'd16383, 28'd1, CFG_DATA_BITS'($urandom_range(1, 300)));
            3: configure(28'd1, 28'd16383, CFG_DATA_BITS'($urandom_range(1, CONSUMED_MAX)));
            4: configure(CFG_DATA_BITS'($urandom_range(1) ? 0 : 5),
                         CFG_DATA_BITS'($urandom_range(1) ? 0 : 3),
                         CFG_DATA_BITS'($urandom_range(1) ? 0 : 10));
            default: configure(CFG_DATA_BITS'($urandom_range(1, 24)),
                               CFG_DATA_BITS'($urandom_range(1, 6)), limit);
        endcase
    endtask

    // One image: mostly well-formed commands with random content, some noise.
    task automatic run_image();
        int n;
        int kind;
        int cnt;
        first_pending = 1'b1;
        n = 0;
        do
        begin
            kind = $urandom_range(99);
            if (kind < 2)
                first_pending = 1'b1;
            if (kind < 36)
            begin
                send_byte(8'(($urandom_range(3) == 0) ? $urandom_range(1, 255)
                                                      : $urandom_range(1, 12)));
                send_byte(8'($urandom_range(255)));
                n += 2;
            end
            else if (kind < 58)
            begin
                cnt = ($urandom_range(29) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 10);
                send_byte(RLE_ESCAPE);
                send_byte(8'(cnt));
                repeat (cnt) send_byte(8'($urandom_range(255)));
                if (cnt % 2 != 0)
                    send_byte(8'($urandom_range(255)));
                n += cnt + 3;
            end
            else if (kind < 70)
            begin
                send_byte(RLE_ESCAPE);
                send_byte(ESC_EOL);
                n += 2;
            end
            else if (kind < 82)
            begin
                send_byte(RLE_ESCAPE);
                send_byte(ESC_DELTA);
                send_byte(8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(4)));
                send_byte(8'(($urandom_range(9) == 0) ? 255 : $urandom_range(2)));
                n += 4;
            end
            else if (kind < 86)
            begin
                send_byte(RLE_ESCAPE);
                send_byte(ESC_EOB);
                n += 2;
            end
            else
            begin
                send_byte(8'($urandom_range(255)));
                n++;
            end
        end
        while (!sb.finished && n < 150);
        // Bytes after the end are ignored by the decoder
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
    endtask

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        int phase_idx;
        int target;
        sb            = new();
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_LINE_STRIDE;
        cfg_data      = '0;
        src_idle      = 0;
        snk_stall     = 0;
        items_sent    = 0;
        first_pending = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a limit of one byte ends the image at once
        first_pending = 1'b1;
        send_byte(8'h07);
        send_byte(8'hFF);
        quiesce();
        write_reg(CFG_UNUSED, CONSUMED_MAX);
        configure(28'd8, 28'd2, CONSUMED_MAX);

        // Encoded run, end of line, odd literal run with pad, delta, even
        // literal run that fills the buffer
        first_pending = 1'b1;
        send_byte(8'h03);
        send_byte(8'hAA);
        send_byte(RLE_ESCAPE);
        send_byte(ESC_EOL);
        send_byte(RLE_ESCAPE);
        send_byte(8'h03);
        send_byte(8'h11);
        send_byte(8'h22);
        send_byte(8'h33);
        send_byte(8'h00);
        send_byte(RLE_ESCAPE);
        send_byte(ESC_DELTA);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(RLE_ESCAPE);
        send_byte(8'h04);
        send_byte(8'hA1);
        send_byte(8'hB2);
        send_byte(8'hC3);
        send_byte(8'hD4);
        // Longest run, clipped at the buffer end
        first_pending = 1'b1;
        send_byte(8'hFF);
        send_byte(8'h5A);
        // End of bitmap right away
        first_pending = 1'b1;
        send_byte(RLE_ESCAPE);
        send_byte(ESC_EOB);
        quiesce();
        // Empty buffer: the first byte ends the image unconsumed
        configure(28'd0, 28'd16383, 28'd20);
        first_pending = 1'b1;
        send_byte(8'h05);
        quiesce();

        for (phase_idx = 0; phase_idx < 4; phase_idx++)
        begin
            case (phase_idx)
                0: begin src_idle = 0;  snk_stall = 0;  end
                1: begin src_idle = 67; snk_stall = 0;  end
                2: begin src_idle = 0;  snk_stall = 67; end
                default: begin src_idle = 12; snk_stall = 12; end
            endcase
            target = items_sent + PHASE_ITEMS;
            pick_config();
            while (items_sent < target)
            begin
                run_image();
                if ($urandom_range(2) == 0)
                begin
                    quiesce();
                    pick_config();
                end
            end
            quiesce();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
